/* src/fbc_pkg.sv */
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_ELEMS   = 16;
    localparam int IN_W        = 1 + 4 + 32 + 6 * 32;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] lo_x;
        logic [31:0] lo_y;
        logic [31:0] lo_z;
        logic [31:0] hi_x;
        logic [31:0] hi_y;
        logic [31:0] hi_z;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DERIVE,
        ST_TEST,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DV_SUM,
        DV_SHIFT,
        DV_SQRT,
        DV_DIV,
        DV_STORE
    } dstate_t;

endpackage

/* src/fbc_front.sv */
// ----------------------------------------------------------------------------
// fbc_front
// Accepts stream items, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module fbc_front
    import fbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_BYTES_W-1:0] s_tdata,
    output logic                  q_valid,
    input  logic                  q_ready,
    output cmd_t                  q_cmd
);

    cmd_t       mem [2];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       push, pop;

    always_comb begin
        dec.op    = op_t'(s_tdata[0]);
        dec.idx   = s_tdata[4:1];
        dec.value = s_tdata[36:5];
        dec.lo_x  = s_tdata[68:37];
        dec.lo_y  = s_tdata[100:69];
        dec.lo_z  = s_tdata[132:101];
        dec.hi_x  = s_tdata[164:133];
        dec.hi_y  = s_tdata[196:165];
        dec.hi_z  = s_tdata[228:197];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem[rd_reg];

    always_comb begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an item");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

/* src/fbc_back.sv */
// ----------------------------------------------------------------------------
// fbc_back
// Stores matrix elements, derives planes and tests boxes one plane per cycle.
// ----------------------------------------------------------------------------
module fbc_back
    import fbc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tdata
);

    localparam int RAW_W = 34;
    localparam int DOT_W = WORD_BITS + 32 + 4;
    localparam int Q_W   = RAW_W + FRAC_BITS + 1;
    localparam logic [Q_W-1:0] LIM = Q_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);

    state_t  state_reg, state_next;
    dstate_t ds_reg;
    logic signed [31:0] mat_reg [NUM_ELEMS];
    logic signed [WORD_BITS-1:0] pl_reg [NUM_PLANES][4];
    cmd_t    cmd_reg;
    logic [2:0] p_reg;
    logic [1:0] j_reg;
    logic       vis_reg;
    logic       out_valid_reg;
    logic       out_data_reg;

    logic signed [RAW_W-1:0] comp [4];
    logic [RAW_W-1:0]        mag  [4];
    logic [5:0]              s_reg, s_next;
    logic [63:0]             rad_reg, root_reg, bit_reg;
    logic [RAW_W+30:0]       den_reg;
    logic [Q_W-1:0]          quo_reg;
    logic [RAW_W+31:0]       rem_reg;
    logic [6:0]              it_reg;
    logic [29:0]             sq_m [3];
    logic [63:0]             mx;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            comp[j] = p_reg[0]
                ? RAW_W'($signed(mat_reg[12 + j])) -
                  RAW_W'($signed(mat_reg[{p_reg[2:1], 2'(j)}]))
                : RAW_W'($signed(mat_reg[12 + j])) +
                  RAW_W'($signed(mat_reg[{p_reg[2:1], 2'(j)}]));
            mag[j] = comp[j][RAW_W-1] ? RAW_W'(-comp[j]) : comp[j];
        end
        mx = 64'(mag[0]);
        if (64'(mag[1]) > mx) mx = 64'(mag[1]);
        if (64'(mag[2]) > mx) mx = 64'(mag[2]);
        s_next = '0;
        for (int s = 0; s < 5; s++)
            if ((mx >> s) >= (64'd1 << 30)) s_next = 6'(s + 1);
        for (int j = 0; j < 3; j++) sq_m[j] = 30'(mag[j] >> s_reg);
    end

    // box test: corner selection per plane sign, one plane per cycle
    logic signed [WORD_BITS-1:0] pa, pb, pc, pd;
    logic signed [31:0] lx, ly, lz, hx, hy, hz;
    logic signed [31:0] cx, cy, cz;
    logic signed [DOT_W-1:0] dot;
    logic [WORD_BITS-1:0] dmag;
    logic below;
    always_comb begin
        pa = pl_reg[p_reg][0];
        pb = pl_reg[p_reg][1];
        pc = pl_reg[p_reg][2];
        pd = pl_reg[p_reg][3];
        lx = $signed(cmd_reg.lo_x);
        ly = $signed(cmd_reg.lo_y);
        lz = $signed(cmd_reg.lo_z);
        hx = $signed(cmd_reg.hi_x);
        hy = $signed(cmd_reg.hi_y);
        hz = $signed(cmd_reg.hi_z);
        // the most positive corner decides whether all eight are below
        cx = ((pa >= 0) == (hx > lx)) ? hx : lx;
        cy = ((pb >= 0) == (hy > ly)) ? hy : ly;
        cz = ((pc >= 0) == (hz > lz)) ? hz : lz;
        dot = DOT_W'(pa) * DOT_W'(cx) + DOT_W'(pb) * DOT_W'(cy) + DOT_W'(pc) * DOT_W'(cz)
            + (DOT_W'(pd) <<< FRAC_BITS);
        dmag = pd[WORD_BITS-1] ? WORD_BITS'(-pd) : pd;
        if (64'(dmag) >= (64'd1 << (58 - FRAC_BITS))) below = pd[WORD_BITS-1];
        else below = dot[DOT_W-1];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = (q_cmd.op == OP_TEST) ? ST_TEST : ST_LOAD;
            ST_LOAD:   state_next = (cmd_reg.idx == 4'd15) ? ST_DERIVE : ST_IDLE;
            ST_DERIVE: if (ds_reg == DV_STORE && j_reg == 2'd3 && p_reg == 3'd5)
                           state_next = ST_IDLE;
            ST_TEST:   if (below || p_reg == 3'd5) state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready = (state_reg == ST_IDLE);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ds_reg        <= DV_SUM;
            p_reg         <= '0;
            j_reg         <= '0;
            for (int i = 0; i < NUM_ELEMS; i++) mat_reg[i] <= '0;
            for (int i = 0; i < NUM_PLANES; i++)
                for (int k = 0; k < 4; k++) pl_reg[i][k] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= vis_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg <= q_cmd;
                        p_reg   <= '0;
                        vis_reg <= 1'b1;
                    end
                end
                ST_LOAD: begin
                    mat_reg[cmd_reg.idx] <= $signed(cmd_reg.value);
                    ds_reg <= DV_SUM;
                    p_reg  <= '0;
                    j_reg  <= '0;
                end
                ST_DERIVE: begin
                    case (ds_reg)
                        DV_SUM: begin
                            s_reg  <= s_next;
                            ds_reg <= DV_SHIFT;
                        end
                        DV_SHIFT: begin
                            rad_reg  <= 64'(sq_m[0]) * 64'(sq_m[0]) +
                                        64'(sq_m[1]) * 64'(sq_m[1]) +
                                        64'(sq_m[2]) * 64'(sq_m[2]);
                            root_reg <= '0;
                            bit_reg  <= 64'd1 << 62;
                            ds_reg   <= DV_SQRT;
                        end
                        DV_SQRT: begin
                            if (bit_reg == 0) begin
                                den_reg <= (RAW_W+31)'(root_reg) << s_reg;
                                j_reg   <= '0;
                                it_reg  <= '0;
                                quo_reg <= '0;
                                rem_reg <= (RAW_W+32)'(mag[0]) << FRAC_BITS;
                                ds_reg  <= DV_DIV;
                            end else begin
                                if (rad_reg >= root_reg + bit_reg) begin
                                    rad_reg  <= rad_reg - (root_reg + bit_reg);
                                    root_reg <= (root_reg >> 1) + bit_reg;
                                end else begin
                                    root_reg <= root_reg >> 1;
                                end
                                bit_reg <= bit_reg >> 2;
                            end
                        end
                        DV_DIV: begin
                            // restoring divide of mag << FRAC_BITS, one bit a cycle
                            if (it_reg == 7'(RAW_W + FRAC_BITS)) begin
                                ds_reg <= DV_STORE;
                            end else begin
                                if ((rem_reg >> (RAW_W + FRAC_BITS - 1 - it_reg)) >=
                                    (RAW_W+32)'(den_reg)) begin
                                    rem_reg <= rem_reg - ((RAW_W+32)'(den_reg) <<
                                               (RAW_W + FRAC_BITS - 1 - it_reg));
                                    quo_reg <= (quo_reg << 1) | Q_W'(1);
                                end else begin
                                    quo_reg <= quo_reg << 1;
                                end
                                it_reg <= it_reg + 7'd1;
                            end
                        end
                        DV_STORE: begin
                            logic [Q_W-1:0] qs;
                            qs = (quo_reg > LIM) ? LIM : quo_reg;
                            if (root_reg == 0) pl_reg[p_reg][j_reg] <= '0;
                            else pl_reg[p_reg][j_reg] <= comp[j_reg][RAW_W-1]
                                ? -$signed(WORD_BITS'(qs)) : $signed(WORD_BITS'(qs));
                            it_reg  <= '0;
                            quo_reg <= '0;
                            if (j_reg == 2'd3) begin
                                j_reg  <= '0;
                                ds_reg <= DV_SUM;
                                if (p_reg != 3'd5) p_reg <= p_reg + 3'd1;
                            end else begin
                                j_reg   <= j_reg + 2'd1;
                                rem_reg <= (RAW_W+32)'(mag[j_reg + 2'd1]) << FRAC_BITS;
                                ds_reg  <= DV_DIV;
                            end
                        end
                        default: ds_reg <= DV_SUM;
                    endcase
                end
                ST_TEST: begin
                    if (below) vis_reg <= 1'b0;
                    p_reg <= p_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEST) |-> p_reg <= 3'd5)
        else $error("plane index out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DERIVE) |-> !q_ready)
        else $error("item taken during derivation");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("held result changed");

endmodule

/* src/frustum_box_cull.sv */
// ----------------------------------------------------------------------------
// frustum_box_cull
// View-frustum test of axis-aligned boxes against six planes from a matrix.
//
//  port group  dir  fields
//  s_*         in   operation, element_index, element_value, box min/max
//  m_*         out  visible
//
// A box test uses one shared dot-product unit, one plane a cycle.
// Loading element 15 derives the planes in the square root and bit-serial divider;
// the queue takes at most two items meanwhile.
// Reset is synchronous, active low; the matrix and plane stores read as zero after it.
// A two-entry queue splits the input side from the back end.
// ----------------------------------------------------------------------------
module frustum_box_cull
    import fbc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // operation, element_index, element_value, min x/y/z, max x/y/z
    input  logic [IN_BYTES_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // visible
    output logic [7:0]            m_tdata
);

    logic q_valid, q_ready, vis;
    cmd_t q_cmd;

    fbc_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    fbc_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata(vis)
    );

    assign m_tdata = {7'd0, vis};

endmodule

/* tb/sv/tb_frustum_box_cull.sv */
// ----------------------------------------------------------------------------
// tb_frustum_box_cull
// Self-checking bench for the frustum box cull block: matrix loads and box
// tests go in on the s_ stream, one visible flag per test comes back on m_.
// A directed table runs first, then random matrices with box tests and noise.
// ----------------------------------------------------------------------------
module tb_frustum_box_cull
    import fbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 16;
    localparam int  N_RANDOM  = 1150;
    localparam int  QUIET_TAIL = 150;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        op_t         op;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] lo_x, lo_y, lo_z;
        logic [31:0] hi_x, hi_y, hi_z;
    } cull_item_t;

    typedef struct {
        cull_item_t item;
        bit         lit;
        bit         lit_vis;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_BYTES_W-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;

    longint mat[16];
    longint pl[24];
    bit     vis_q[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_tests = 0;
    int     n_hidden = 0;
    int     n_derive = 0;
    longint cycles = 0;
    bit     quiet = 1'b0;
    dir_row_t rows[$];

    frustum_box_cull i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_frustum_box_cull failed");
            $finish;
        end
    end

    function automatic logic [IN_BYTES_W-1:0] pack_item(cull_item_t it);
        logic [IN_BYTES_W-1:0] d;
        d = '0;
        d[0]       = it.op;
        d[4:1]     = it.idx;
        d[36:5]    = it.val;
        d[68:37]   = it.lo_x;
        d[100:69]  = it.lo_y;
        d[132:101] = it.lo_z;
        d[164:133] = it.hi_x;
        d[196:165] = it.hi_y;
        d[228:197] = it.hi_z;
        return d;
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned scaled_quot(longint unsigned num,
            longint unsigned den, longint unsigned lim);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q > lim) return lim;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q + 1;
            end
            if (q > lim) return lim;
        end
        return q;
    endfunction

    function automatic void derive_planes();
        longint unsigned lim, mx, sum, t, m, q;
        longint comp[4];
        longint unsigned mag[4];
        int s, row;
        lim = (64'd1 << 31) - 1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            row = p >> 1;
            mx = 0;
            sum = 0;
            s = 0;
            for (int j = 0; j < 4; j++) begin
                comp[j] = (p & 1) ? mat[12 + j] - mat[row * 4 + j]
                                  : mat[12 + j] + mat[row * 4 + j];
                mag[j] = comp[j] < 0 ? longint'(-comp[j]) : comp[j];
            end
            for (int j = 0; j < 3; j++)
                if (mag[j] > mx) mx = mag[j];
            while ((mx >> s) >= (64'd1 << 30)) s++;
            for (int j = 0; j < 3; j++) begin
                m = mag[j] >> s;
                sum = sum + m * m;
            end
            t = int_sqrt(sum);
            for (int j = 0; j < 4; j++) begin
                pl[p * 4 + j] = 0;
                if (t != 0) begin
                    q = scaled_quot(mag[j], t << s, lim);
                    pl[p * 4 + j] = comp[j] < 0 ? -longint'(q) : longint'(q);
                end
            end
        end
    endfunction

    function automatic bit corner_below(int p, longint x, longint y, longint z);
        longint partial, d;
        longint unsigned dmag;
        d = pl[p * 4 + 3];
        partial = pl[p * 4] * x + pl[p * 4 + 1] * y + pl[p * 4 + 2] * z;
        dmag = d < 0 ? longint'(-d) : d;
        if (dmag >= (64'd1 << (58 - FRAC))) return d < 0;
        return (partial + d * (longint'(1) << FRAC)) < 0;
    endfunction

    function automatic bit box_visible(cull_item_t it);
        longint lo[3], hi[3];
        int cnt;
        lo[0] = sx(it.lo_x); lo[1] = sx(it.lo_y); lo[2] = sx(it.lo_z);
        hi[0] = sx(it.hi_x); hi[1] = sx(it.hi_y); hi[2] = sx(it.hi_z);
        for (int p = 0; p < NUM_PLANES; p++) begin
            cnt = 0;
            for (int k = 0; k < 8; k++)
                if (corner_below(p, (k & 1) ? hi[0] : lo[0], (k & 2) ? hi[1] : lo[1],
                                 (k & 4) ? hi[2] : lo[2]))
                    cnt++;
            if (cnt == 8) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic cull_item_t load_item(int idx, logic [31:0] v);
        cull_item_t it;
        it.op = OP_LOAD; it.idx = idx[3:0]; it.val = v;
        it.lo_x = $urandom; it.lo_y = $urandom; it.lo_z = $urandom;
        it.hi_x = $urandom; it.hi_y = $urandom; it.hi_z = $urandom;
        return it;
    endfunction

    function automatic cull_item_t box_item(logic [31:0] lx, logic [31:0] ly,
            logic [31:0] lz, logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        cull_item_t it;
        it.op = OP_TEST; it.idx = 4'($urandom); it.val = $urandom;
        it.lo_x = lx; it.lo_y = ly; it.lo_z = lz;
        it.hi_x = hx; it.hi_y = hy; it.hi_z = hz;
        return it;
    endfunction

    function automatic void add_row(cull_item_t it, bit lit, bit v);
        dir_row_t r;
        r.item = it; r.lit = lit; r.lit_vis = v;
        rows.insert(rows.size(), r);
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'd0;
            default: return $urandom_range(0, 8 << FRAC) - (4 << FRAC);
        endcase
    endfunction

    function automatic cull_item_t rand_box();
        int c[3], h[3];
        if ($urandom_range(0, 7) == 0)
            return box_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 3; i++) begin
            c[i] = $urandom_range(0, 12 << FRAC) - (6 << FRAC);
            h[i] = $urandom_range(0, 2 << FRAC);
        end
        return box_item(c[0] - h[0], c[1] - h[1], c[2] - h[2],
                        c[0] + h[0], c[1] + h[1], c[2] + h[2]);
    endfunction

    task automatic send_item(cull_item_t it, bit lit, bit lit_vis);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (it.op == OP_TEST) begin
            vis_q.insert(vis_q.size(), lit ? lit_vis : box_visible(it));
            n_tests++;
        end else begin
            mat[it.idx] = sx(it.val);
            if (it.idx == 4'd15) begin
                derive_planes();
                n_derive++;
            end
        end
    endtask

    task automatic send_matrix(longint m[16]);
        for (int i = 0; i < 16; i++)
            send_item(load_item(i, m[i][31:0]), 1'b0, 1'b0);
    endtask

    initial begin
        int gap;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (vis_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %0d", m_tdata[0]);
            end else begin
                bit want;
                want = vis_q.pop_front();
                if (m_tdata[0] !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("visible mismatch: expected %0d got %0d", want, m_tdata[0]);
                end
            end
        end
    end

    initial begin
        longint m[16];
        cull_item_t it;
        longint wait_cnt;
        int r;
        for (int i = 0; i < 16; i++) mat[i] = 0;
        for (int i = 0; i < 24; i++) pl[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset all planes are zero: every box visible
        add_row(box_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 1'b1, 1'b1);
        add_row(box_item(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000), 1'b1, 1'b1);
        add_row(box_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 32'h80000000), 1'b1, 1'b1);
        // zero matrix derived: zero root keeps every box visible
        add_row(load_item(15, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b1, 1'b1);
        // identity matrix: unit cube frustum
        add_row(load_item(0, 32'h00010000), 1'b0, 1'b0);
        add_row(load_item(5, 32'h00010000), 1'b0, 1'b0);
        add_row(load_item(10, 32'h00010000), 1'b0, 1'b0);
        add_row(load_item(15, 32'h00010000), 1'b0, 1'b0);
        add_row(box_item(32'h00020000, 32'h0, 32'h0, 32'h00030000, 32'h0, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'hfff00000, 32'h0, 32'h0, 32'hfffe0000, 32'h0, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'h0, 32'h0, 32'h0, 32'h00008000, 32'h8000, 32'h8000), 1'b0, 1'b0);
        add_row(box_item(32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'h00030000, 32'h0, 32'h0, 32'hfffd0000, 32'h0, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0, 1'b0);
        add_row(box_item(32'h0, 32'h00050000, 32'h0, 32'h0, 32'h00060000, 32'h0), 1'b0, 1'b0);
        // extreme elements: saturating components
        add_row(load_item(0, 32'h80000000), 1'b0, 1'b0);
        add_row(load_item(3, 32'h7fffffff), 1'b0, 1'b0);
        add_row(load_item(12, 32'h00000001), 1'b0, 1'b0);
        add_row(load_item(15, 32'h7fffffff), 1'b0, 1'b0);
        add_row(box_item(32'h7fffffff, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'h80000000, 32'h1, 32'h1, 32'h80000000, 32'h1, 32'h1), 1'b0, 1'b0);
        add_row(load_item(15, 32'h80000000), 1'b0, 1'b0);
        add_row(box_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 1'b0, 1'b0);
        add_row(box_item(32'hffffffff, 32'hffffffff, 32'hffffffff,
                         32'hffffffff, 32'hffffffff, 32'hffffffff), 1'b0, 1'b0);

        foreach (rows[i]) send_item(rows[i].item, rows[i].lit, rows[i].lit_vis);

        r = 0;
        while (r < N_RANDOM) begin
            if (N_RANDOM - r < QUIET_TAIL) quiet = 1'b1;
            case ($urandom_range(0, 39))
                0, 1, 2, 3: begin
                    if ($urandom_range(0, 1)) begin
                        it = load_item($urandom_range(0, 15), $urandom);
                    end else begin
                        it = box_item($urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom);
                    end
                    it.op = op_t'($urandom_range(0, 1));
                    send_item(it, 1'b0, 1'b0);
                    r++;
                end
                4: begin
                    for (int i = 0; i < 16; i++) m[i] = rand_elem();
                    if ($urandom_range(0, 1)) begin
                        for (int i = 0; i < 12; i++) m[i] = 0;
                        m[0] = 1 << FRAC; m[5] = 1 << FRAC; m[10] = 1 << FRAC;
                        m[15] = $urandom_range(1, 4) << FRAC;
                    end
                    // drop the final element on a broken sequence
                    if ($urandom_range(0, 5) == 0) begin
                        for (int i = 0; i < 15; i++)
                            send_item(load_item(i, m[i][31:0]), 1'b0, 1'b0);
                        r += 15;
                    end else begin
                        send_matrix(m);
                        r += 16;
                    end
                end
                default: begin
                    send_item(rand_box(), 1'b0, 1'b0);
                    r++;
                end
            endcase
        end
        quiet = 1'b1;
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (vis_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (2000) @(posedge aclk);

        $display("covered %0d items: %0d box tests (%0d hidden), %0d plane derivations",
                 n_sent, n_tests, n_hidden, n_derive);
        if (errors == 0 && vis_q.size() == 0) begin
            $display("tb_frustum_box_cull passed");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, vis_q.size());
            $display("tb_frustum_box_cull failed");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tdata[0] == 1'b0) n_hidden++;
    end

endmodule

/* files.f */
src/fbc_pkg.sv
src/fbc_front.sv
src/fbc_back.sv
src/frustum_box_cull.sv
tb/sv/tb_frustum_box_cull.sv
